### rtl/core/jfs_pkg.sv
package jfs_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned WORD_W  = 16;
    localparam int unsigned PHASE_W = 4;
    localparam int unsigned CFG_IDX_W = 2;

    typedef logic [BYTE_W-1:0]    t_byte;
    typedef logic [WORD_W-1:0]    t_word;
    typedef logic [PHASE_W-1:0]   t_phase;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_TARGET_WIDTH  = 2'd0;
    localparam t_cfg_idx CFG_TARGET_HEIGHT = 2'd1;

    localparam t_word TARGET_WIDTH_RST  = 16'd1920;
    localparam t_word TARGET_HEIGHT_RST = 16'd1080;

    localparam t_byte BYTE_PREFIX = 8'hFF;
    localparam t_byte BYTE_SOI    = 8'hD8;
    localparam t_byte BYTE_SOF0   = 8'hC0;
    localparam t_byte BYTE_SOF2   = 8'hC2;

    localparam t_word SOF_SKIP = 16'd3;
    localparam t_word LEN_MIN  = 16'd2;

    localparam t_phase PH_START0  = 4'd0;
    localparam t_phase PH_START1  = 4'd1;
    localparam t_phase PH_NOTJPEG = 4'd2;
    localparam t_phase PH_HUNT    = 4'd3;
    localparam t_phase PH_MARKER  = 4'd4;
    localparam t_phase PH_SOFSKIP = 4'd5;
    localparam t_phase PH_HHI     = 4'd6;
    localparam t_phase PH_HLO     = 4'd7;
    localparam t_phase PH_WHI     = 4'd8;
    localparam t_phase PH_WLO     = 4'd9;
    localparam t_phase PH_LENHI   = 4'd10;
    localparam t_phase PH_LENLO   = 4'd11;
    localparam t_phase PH_SKIP    = 4'd12;

endpackage

### rtl/core/jpeg_frame_size_scanner.sv
// Channel  | valid         | stall / ready   | payload
// -------- | ------------- | --------------- | -----------------------------------------
// byte in  | i_in_valid    | o_in_stall      | i_data_byte, i_last_byte
// result   | o_out_valid   | i_out_stall     | o_is_jpeg, o_frame_width, o_frame_height,
//          |               |                 | o_size_matches
// config   | i_cfg_valid   | o_cfg_ready     | i_cfg_index, i_cfg_data
//
// One byte per cycle while o_in_stall is low. A byte is registered on transfer
// and parsed from the byte register; a last byte's result is then registered for output.
// Synchronous active-low reset clears the parser and the byte and result valid
// flags and loads the default targets. A stalled result holds the byte register;
// the byte register still refills when its content needs no result slot.
module jpeg_frame_size_scanner (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  jfs_pkg::t_byte     i_data_byte,
    input  logic               i_last_byte,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_is_jpeg,
    output jfs_pkg::t_word     o_frame_width,
    output jfs_pkg::t_word     o_frame_height,
    output logic               o_size_matches,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  jfs_pkg::t_cfg_idx  i_cfg_index,
    input  jfs_pkg::t_word     i_cfg_data
);
    import jfs_pkg::*;

    t_word  r_target_w, r_target_h;

    logic   r_in_valid;
    t_byte  r_byte;
    logic   r_last;

    t_phase r_phase, n_phase;
    t_word  r_skip, n_skip;
    t_byte  r_len_hi, n_len_hi;
    t_word  r_width, n_width;
    t_word  r_height, n_height;
    logic   r_jpeg, n_jpeg;

    logic   r_out_valid;
    logic   r_out_jpeg;
    t_word  r_out_w, r_out_h;
    logic   r_out_match;

    logic   out_free;
    logic   advance;
    logic   emit;
    t_word  word_val;
    t_word  skip_dec;
    t_word  res_w, res_h;

    assign o_cfg_ready = 1'b1;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && (out_free || !r_last);
    assign o_in_stall = r_in_valid && !advance;
    assign emit       = advance && r_last;

    assign word_val = {r_len_hi, r_byte};
    assign skip_dec = r_skip - 16'd1;

    always_comb begin
        n_phase  = r_phase;
        n_skip   = r_skip;
        n_len_hi = r_len_hi;
        n_width  = r_width;
        n_height = r_height;
        n_jpeg   = r_jpeg;
        case (r_phase)
            PH_START0: begin
                n_phase = (r_byte == BYTE_PREFIX) ? PH_START1 : PH_NOTJPEG;
            end
            PH_START1: begin
                if (r_byte == BYTE_SOI) begin
                    n_jpeg  = 1'b1;
                    n_phase = PH_HUNT;
                end else begin
                    n_phase = PH_NOTJPEG;
                end
            end
            PH_HUNT: begin
                if (r_byte == BYTE_PREFIX) begin
                    n_phase = PH_MARKER;
                end
            end
            PH_MARKER: begin
                if (r_byte == BYTE_SOF0 || r_byte == BYTE_SOF2) begin
                    n_skip  = SOF_SKIP;
                    n_phase = PH_SOFSKIP;
                end else begin
                    n_phase = PH_LENHI;
                end
            end
            PH_SOFSKIP: begin
                n_skip = skip_dec;
                if (skip_dec == '0) begin
                    n_phase = PH_HHI;
                end
            end
            PH_HHI: begin
                n_len_hi = r_byte;
                n_phase  = PH_HLO;
            end
            PH_HLO: begin
                n_skip  = word_val;
                n_phase = PH_WHI;
            end
            PH_WHI: begin
                n_len_hi = r_byte;
                n_phase  = PH_WLO;
            end
            PH_WLO: begin
                n_width  = word_val;
                n_height = r_skip;
                n_skip   = '0;
                n_phase  = PH_HUNT;
            end
            PH_LENHI: begin
                n_len_hi = r_byte;
                n_phase  = PH_LENLO;
            end
            PH_LENLO: begin
                if (word_val <= LEN_MIN) begin
                    n_skip  = '0;
                    n_phase = PH_HUNT;
                end else begin
                    n_skip  = word_val - LEN_MIN;
                    n_phase = PH_SKIP;
                end
            end
            PH_SKIP: begin
                n_skip = skip_dec;
                if (skip_dec == '0) begin
                    n_phase = PH_HUNT;
                end
            end
            default: begin
                n_phase = PH_NOTJPEG;
            end
        endcase
    end

    assign res_w = n_jpeg ? n_width  : '0;
    assign res_h = n_jpeg ? n_height : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_w <= TARGET_WIDTH_RST;
            r_target_h <= TARGET_HEIGHT_RST;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_TARGET_WIDTH) begin
                r_target_w <= i_cfg_data;
            end else if (i_cfg_index == CFG_TARGET_HEIGHT) begin
                r_target_h <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_byte <= i_data_byte;
            r_last <= i_last_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || emit) begin
            r_phase  <= PH_START0;
            r_skip   <= '0;
            r_len_hi <= '0;
            r_width  <= '0;
            r_height <= '0;
            r_jpeg   <= 1'b0;
        end else if (advance) begin
            r_phase  <= n_phase;
            r_skip   <= n_skip;
            r_len_hi <= n_len_hi;
            r_width  <= n_width;
            r_height <= n_height;
            r_jpeg   <= n_jpeg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_jpeg  <= n_jpeg;
            r_out_w     <= res_w;
            r_out_h     <= res_h;
            r_out_match <= (res_w == r_target_w) && (res_h == r_target_h);
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_is_jpeg      = r_out_jpeg;
    assign o_frame_width  = r_out_w;
    assign o_frame_height = r_out_h;
    assign o_size_matches = r_out_match;

endmodule

### rtl/core/jfs_checker.sv
module jfs_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               o_out_valid,
    input  logic               i_out_stall,
    input  logic               o_is_jpeg,
    input  jfs_pkg::t_word     o_frame_width,
    input  jfs_pkg::t_word     o_frame_height,
    input  logic               o_size_matches,
    input  logic               i_cfg_valid,
    input  logic               o_cfg_ready,
    input  jfs_pkg::t_cfg_idx  i_cfg_index,
    input  jfs_pkg::t_word     i_cfg_data
);
    import jfs_pkg::*;

    t_word r_tw, r_th;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tw <= TARGET_WIDTH_RST;
            r_th <= TARGET_HEIGHT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == CFG_TARGET_WIDTH) begin
                r_tw <= i_cfg_data;
            end else if (i_cfg_index == CFG_TARGET_HEIGHT) begin
                r_th <= i_cfg_data;
            end
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_not_jpeg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_is_jpeg |-> o_frame_width == '0 && o_frame_height == '0)
        else $error("non-JPEG result with nonzero size");

    a_match_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_size_matches == (o_frame_width == r_tw && o_frame_height == r_th))
        else $error("match flag disagrees with targets");

endmodule

bind jpeg_frame_size_scanner jfs_checker u_jfs_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_is_jpeg      (o_is_jpeg),
    .o_frame_width  (o_frame_width),
    .o_frame_height (o_frame_height),
    .o_size_matches (o_size_matches),
    .i_cfg_valid    (i_cfg_valid),
    .o_cfg_ready    (o_cfg_ready),
    .i_cfg_index    (i_cfg_index),
    .i_cfg_data     (i_cfg_data)
);
